// ----- hw/rtl/xcfr_pkg.sv -----
// Shared types and constants for the XOR-checked frame receiver.
// No dependencies; imported by every module of the block.
package xcfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int PLEN_W          = 6;
  localparam int DEF_MAX_PAYLOAD = 32;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // result of the shared byte comparator
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ----- hw/rtl/xcfr_cmp.sv -----
// Shared byte comparator used by the sequencer for every marker, bound,
// index and checksum test. Depends on xcfr_pkg.
module xcfr_cmp
  import xcfr_pkg::*;
(
  input  logic [BYTE_W-1:0] op_a,
  input  logic [BYTE_W-1:0] op_b,
  output cmp_res_t          res
);

  assign res.eq = (op_a == op_b);
  assign res.gt = (op_a > op_b);

endmodule

// ----- hw/rtl/xcfr_store.sv -----
// Payload memory: one write port, one read port with registered read data.
// Depends on xcfr_pkg.
module xcfr_store
  import xcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD,
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [BYTE_W-1:0]    wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [BYTE_W-1:0]    rd_data
);

  logic [BYTE_W-1:0] mem_r [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/xcfr_seq.sv -----
// Frame sequencer: parses the byte stream, drives the shared comparator and
// the payload memory, and holds the result output register.
// Depends on xcfr_pkg, xcfr_cmp and xcfr_store.
module xcfr_seq
  import xcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] start_marker,
  input  logic [BYTE_W-1:0] end_marker,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_command_id,
  output logic              out_frame_status,
  output logic [PLEN_W-1:0] out_payload_length,
  output logic              out_has_payload_byte,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic              out_last_of_frame
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  // sequencer states
  localparam logic [2:0] ST_WAIT  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_ONE   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  // position within the frame
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_CHK  = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] chk_r, chk_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              end_ok_r, end_ok_nxt;
  logic              bad_r, bad_nxt;
  logic              last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] o_cmd_r, o_cmd_nxt;
  logic              o_status_r, o_status_nxt;
  logic [PLEN_W-1:0] o_len_r, o_len_nxt;
  logic              o_has_r, o_has_nxt;
  logic [BYTE_W-1:0] o_byte_r, o_byte_nxt;
  logic              o_last_r, o_last_nxt;

  logic [BYTE_W-1:0] cmp_a, cmp_b;
  cmp_res_t          cmp_res;
  logic              mem_we, mem_re;
  logic [BYTE_W-1:0] mem_rdata;
  logic              out_free;
  logic              load;
  logic [BYTE_W-1:0] idx_plus1;
  logic [BYTE_W-1:0] len_byte;

  assign idx_plus1 = BYTE_W'(idx_r) + BYTE_W'(1);
  assign len_byte  = BYTE_W'(len_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_WAIT);

  // operand select for the shared comparator
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      ST_EXEC: begin
        case (phase_r)
          PH_HUNT: begin
            cmp_a = byte_r;
            cmp_b = start_marker;
          end
          PH_LEN: begin
            cmp_a = byte_r;
            cmp_b = BYTE_W'(MAX_PAYLOAD);
          end
          PH_PAY: begin
            cmp_a = idx_plus1;
            cmp_b = len_byte;
          end
          PH_END: begin
            cmp_a = byte_r;
            cmp_b = end_marker;
          end
          default: begin
            cmp_a = '0;
            cmp_b = '0;
          end
        endcase
      end
      ST_CHECK: begin
        cmp_a = xor_r;
        cmp_b = chk_r;
      end
      ST_RD: begin
        cmp_a = idx_plus1;
        cmp_b = len_byte;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  xcfr_cmp u_cmp (
    .op_a (cmp_a),
    .op_b (cmp_b),
    .res  (cmp_res)
  );

  assign mem_we = (state_r == ST_EXEC) && (phase_r == PH_PAY);
  assign mem_re = (state_r == ST_RD);

  xcfr_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (idx_r),
    .wr_data (byte_r),
    .rd_en   (mem_re),
    .rd_addr (idx_r),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    byte_nxt     = byte_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    xor_nxt      = xor_r;
    chk_nxt      = chk_r;
    idx_nxt      = idx_r;
    end_ok_nxt   = end_ok_r;
    bad_nxt      = bad_r;
    last_nxt     = last_r;
    load         = 1'b0;
    o_cmd_nxt    = o_cmd_r;
    o_status_nxt = o_status_r;
    o_len_nxt    = o_len_r;
    o_has_nxt    = o_has_r;
    o_byte_nxt   = o_byte_r;
    o_last_nxt   = o_last_r;

    case (state_r)
      ST_WAIT: begin
        if (in_valid) begin
          byte_nxt  = in_rx_byte;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_WAIT;
        case (phase_r)
          PH_HUNT: begin
            if (cmp_res.eq) begin
              phase_nxt = PH_CMD;
              xor_nxt   = '0;
            end
          end
          PH_CMD: begin
            cmd_nxt   = byte_r;
            xor_nxt   = byte_r;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            // oversize length: drop the frame, byte is consumed
            if (cmp_res.gt) begin
              phase_nxt = PH_HUNT;
            end else begin
              len_nxt   = LEN_W'(byte_r);
              xor_nxt   = xor_r ^ byte_r;
              idx_nxt   = '0;
              phase_nxt = (byte_r == '0) ? PH_CHK : PH_PAY;
            end
          end
          PH_PAY: begin
            xor_nxt = xor_r ^ byte_r;
            if (cmp_res.eq) begin
              phase_nxt = PH_CHK;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          PH_CHK: begin
            chk_nxt   = byte_r;
            phase_nxt = PH_END;
          end
          PH_END: begin
            end_ok_nxt = cmp_res.eq;
            phase_nxt  = PH_HUNT;
            state_nxt  = ST_CHECK;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
      ST_CHECK: begin
        idx_nxt = '0;
        if (!(end_ok_r && cmp_res.eq)) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_ONE;
        end else if (len_r == '0) begin
          bad_nxt   = 1'b0;
          state_nxt = ST_ONE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_ONE: begin
        if (out_free) begin
          load         = 1'b1;
          o_cmd_nxt    = cmd_r;
          o_status_nxt = bad_r;
          o_len_nxt    = '0;
          o_has_nxt    = 1'b0;
          o_byte_nxt   = '0;
          o_last_nxt   = 1'b1;
          state_nxt    = ST_WAIT;
        end
      end
      ST_RD: begin
        last_nxt  = cmp_res.eq;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // read data holds until the output register takes it
        if (out_free) begin
          load         = 1'b1;
          o_cmd_nxt    = cmd_r;
          o_status_nxt = 1'b0;
          o_len_nxt    = PLEN_W'(len_r);
          o_has_nxt    = 1'b1;
          o_byte_nxt   = mem_rdata;
          o_last_nxt   = last_r;
          if (last_r) begin
            state_nxt = ST_WAIT;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      phase_r     <= PH_HUNT;
      cmd_r       <= '0;
      len_r       <= '0;
      xor_r       <= '0;
      chk_r       <= '0;
      idx_r       <= '0;
      end_ok_r    <= 1'b0;
      bad_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      len_r       <= len_nxt;
      xor_r       <= xor_nxt;
      chk_r       <= chk_nxt;
      idx_r       <= idx_nxt;
      end_ok_r    <= end_ok_nxt;
      bad_r       <= bad_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    o_cmd_r    <= o_cmd_nxt;
    o_status_r <= o_status_nxt;
    o_len_r    <= o_len_nxt;
    o_has_r    <= o_has_nxt;
    o_byte_r   <= o_byte_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_command_id       = o_cmd_r;
  assign out_frame_status     = o_status_r;
  assign out_payload_length   = o_len_r;
  assign out_has_payload_byte = o_has_r;
  assign out_payload_byte     = o_byte_r;
  assign out_last_of_frame    = o_last_r;

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_valid_r |-> !out_stall)
    else $error("result loaded over a pending result");

  // an accepted byte is always processed in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_EXEC)
    else $error("accepted byte not processed");

  // drain reads stay inside the frame's payload
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> BYTE_W'(idx_r) < len_byte)
    else $error("payload read beyond frame length");

  // the final result of a frame returns the block to taking bytes
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load && o_last_nxt |=> state_r == ST_WAIT)
    else $error("sequencer busy after final result");

  // a bad frame gives a single result with no payload
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r |-> o_last_r && !o_has_r)
    else $error("bad frame result carries payload");

endmodule

// ----- hw/rtl/xor_checked_frame_receiver_top.sv -----
// Top level of the XOR-checked frame receiver: configuration registers on
// an APB-style port and the frame sequencer. Depends on xcfr_pkg, xcfr_seq.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per transaction. A frame is start marker, command, length, payload,
//   XOR checksum (over command, length, payload) and end marker. Bytes
//   outside a frame other than the start marker are ignored; a length above
//   MAX_PAYLOAD drops the frame.
//   Result channel (out_valid / out_stall / out_*) gives one transaction per
//   payload byte of a good frame, one payload-less transaction for a good
//   empty frame, or one transaction with frame_status set for a bad frame.
//   Each byte is registered, then handled in a sequencer step through the
//   shared comparator; the end byte adds a step for the checksum compare.
//   Each result drains as a memory read, then an output register load; the
//   input stays stalled from the end byte until the frame's last result is
//   loaded, also for a bad or empty frame.
//   A result waiting in the output register does not block the next byte.
//   When the receiver stalls, the output register holds and the drain waits.
//   Reset (rst_n low, synchronous) clears the markers to 0xAA / 0x55 and
//   puts the block in hunt; the payload memory is not cleared.
module xor_checked_frame_receiver_top
  import xcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_command_id,
  output logic                  out_frame_status,
  output logic [PLEN_W-1:0]     out_payload_length,
  output logic                  out_has_payload_byte,
  output logic [BYTE_W-1:0]     out_payload_byte,
  output logic                  out_last_of_frame
);

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] end_marker_r;
  logic              cfg_wr;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_START_MARKER: start_marker_r <= pwdata[BYTE_W-1:0];
        REG_END_MARKER:   end_marker_r   <= pwdata[BYTE_W-1:0];
        default:          start_marker_r <= start_marker_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_MARKER: prdata = CFG_DATA_W'(start_marker_r);
      REG_END_MARKER:   prdata = CFG_DATA_W'(end_marker_r);
      default:          prdata = '0;
    endcase
  end

  xcfr_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start_marker         (start_marker_r),
    .end_marker           (end_marker_r),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_command_id       (out_command_id),
    .out_frame_status     (out_frame_status),
    .out_payload_length   (out_payload_length),
    .out_has_payload_byte (out_has_payload_byte),
    .out_payload_byte     (out_payload_byte),
    .out_last_of_frame    (out_last_of_frame)
  );

endmodule

// ----- sim/tb_xor_checked_frame_receiver_top.sv -----
`timescale 1ns / 100ps
// Testbench for xor_checked_frame_receiver_top: sends framed byte streams,
// tracks the frame parser state alongside the block and checks every result
// in order. Depends on xcfr_pkg and the receiver RTL.
module tb_xor_checked_frame_receiver_top;
  import xcfr_pkg::*;

  localparam int MAX_LEN        = DEF_MAX_PAYLOAD;
  localparam int HEADER_BYTES   = 3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 2 * MAX_LEN + 16;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {FLAW_NONE, FLAW_BAD_CHECK, FLAW_BAD_END} frame_flaw_t;
  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic [BYTE_W-1:0] command_id;
    logic              frame_status;
    logic [PLEN_W-1:0] payload_length;
    logic              has_payload_byte;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_command_id;
  logic                  out_frame_status;
  logic [PLEN_W-1:0]     out_payload_length;
  logic                  out_has_payload_byte;
  logic [BYTE_W-1:0]     out_payload_byte;
  logic                  out_last_of_frame;

  xor_checked_frame_receiver_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser state as the block should hold it
  logic [BYTE_W-1:0] exp_start_marker = START_MARKER_RST;
  logic [BYTE_W-1:0] exp_end_marker   = END_MARKER_RST;
  logic              rx_in_frame = 1'b0;
  int                rx_pos = 0;
  logic [BYTE_W-1:0] rx_cmd = '0;
  int                rx_len = 0;
  logic [BYTE_W-1:0] rx_xor = '0;
  logic [BYTE_W-1:0] rx_check = '0;
  logic [BYTE_W-1:0] rx_store[MAX_LEN];

  frame_result_t due_results[$];
  int            mismatches = 0;
  int            idle_cycles = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  int            rx_hold = 0;

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) note_failure($sformatf("%s: expected %0h, got %0h", name, want, got));
  endfunction

  function automatic void push_result(input logic status, input logic [PLEN_W-1:0] len,
                                      input logic has, input logic [BYTE_W-1:0] data,
                                      input logic last);
    frame_result_t r;
    r.command_id       = rx_cmd;
    r.frame_status     = status;
    r.payload_length   = len;
    r.has_payload_byte = has;
    r.payload_byte     = data;
    r.last_of_frame    = last;
    due_results.push_back(r);
  endfunction

  // Advance the parser by one accepted byte and queue the results it causes.
  function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
    int   p;
    logic good;
    if (!rx_in_frame) begin
      if (b == exp_start_marker) begin
        rx_in_frame = 1'b1;
        rx_pos      = 1;
        rx_xor      = '0;
      end
      return;
    end
    p = rx_pos;
    if (p == 1) begin
      rx_cmd = b;
      rx_xor = b;
    end else if (p == 2) begin
      if (int'(b) > MAX_LEN) begin
        // oversize length: drop the frame, back to hunting
        rx_in_frame = 1'b0;
        rx_pos      = 0;
        return;
      end
      rx_len = int'(b);
      rx_xor ^= b;
    end else if (p < HEADER_BYTES + rx_len) begin
      rx_store[p - HEADER_BYTES] = b;
      rx_xor ^= b;
    end else if (p == HEADER_BYTES + rx_len) begin
      rx_check = b;
    end else begin
      good        = (b == exp_end_marker) && (rx_xor == rx_check);
      rx_in_frame = 1'b0;
      rx_pos      = 0;
      if (!good) begin
        push_result(1'b1, '0, 1'b0, '0, 1'b1);
      end else if (rx_len == 0) begin
        push_result(1'b0, '0, 1'b0, '0, 1'b1);
      end else begin
        for (int i = 0; i < rx_len; i++)
          push_result(1'b0, PLEN_W'(rx_len), 1'b1, rx_store[i], (i + 1 == rx_len));
      end
      return;
    end
    rx_pos = p + 1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic byte_q_t random_payload(input int n);
    byte_q_t q;
    repeat (n) q.push_back(BYTE_W'($urandom()));
    return q;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_rx_byte(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input byte_q_t data,
                            input frame_flaw_t flaw);
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] tail;
    chk  = cmd ^ BYTE_W'(data.size());
    tail = exp_end_marker;
    foreach (data[i]) chk ^= data[i];
    if (flaw == FLAW_BAD_CHECK) chk ^= BYTE_W'($urandom_range(1, 255));
    if (flaw == FLAW_BAD_END) tail ^= BYTE_W'($urandom_range(1, 255));
    send_byte(exp_start_marker);
    send_byte(cmd);
    send_byte(BYTE_W'(data.size()));
    foreach (data[i]) send_byte(data[i]);
    send_byte(chk);
    send_byte(tail);
  endtask

  // Hold the input until every queued result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic cfg_write(input logic idx, input logic [BYTE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(idx));
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_START_MARKER) exp_start_marker = value;
    else exp_end_marker = value;
    @(posedge clk);
  endtask

  task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
    // close any frame still open so the markers change between frames
    while (rx_in_frame) send_byte(8'hFF);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(REG_START_MARKER, s);
    cfg_write(REG_END_MARKER, e);
  endtask

  task automatic test_good_frames();
    byte_q_t none;
    send_frame(8'h00, none, FLAW_NONE);
    // start marker as command and payload is plain frame data
    send_frame(exp_start_marker, {exp_start_marker, 8'h00, 8'hFF}, FLAW_NONE);
  endtask

  task automatic test_bad_frames();
    byte_q_t none;
    send_frame(8'hFF, none, FLAW_BAD_CHECK);
    send_frame(8'h5A, {8'h01}, FLAW_BAD_END);
  endtask

  task automatic test_dropped_frames();
    // ignored while hunting under the reset markers
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(exp_start_marker);
    send_byte(8'h11);
    send_byte(8'(MAX_LEN + 1));
    send_byte(exp_start_marker);
    send_byte(8'h22);
    send_byte(8'hFF);
  endtask

  task automatic test_back_to_back();
    byte_q_t none;
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    send_frame(8'($urandom()), random_payload(MAX_LEN), FLAW_NONE);
    send_frame(8'($urandom()), random_payload(1), FLAW_NONE);
    send_frame(8'($urandom()), none, FLAW_BAD_END);
    send_frame(8'($urandom()), random_payload(2), FLAW_BAD_CHECK);
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  task automatic test_drain_pause();
    send_frame(8'($urandom()), random_payload(4), FLAW_NONE);
    wait_for_results();
    send_frame(8'($urandom()), random_payload(3), FLAW_NONE);
  endtask

  task automatic test_random_frames(input int n_bytes);
    int          sent;
    int          r;
    int          len;
    frame_flaw_t flaw;
    byte_q_t     data;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_quiet = ~tx_quiet;
        rx_quiet <= 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // line noise: ignored while hunting, may open a frame
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
      end else if (r < 14) begin
        // truncated frame: the next start byte lands inside it as data
        len = $urandom_range(0, 8);
        data = random_payload($urandom_range(0, len));
        send_byte(exp_start_marker);
        send_byte(8'($urandom()));
        send_byte(8'(len));
        foreach (data[i]) send_byte(data[i]);
        sent += HEADER_BYTES + data.size();
      end else if (r < 20) begin
        send_byte(exp_start_marker);
        send_byte(8'($urandom()));
        send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
        sent += HEADER_BYTES;
      end else if (r < 24) begin
        wait_for_results();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) len = MAX_LEN;
        else if (r < 12) len = 0;
        else len = $urandom_range(1, 6);
        r = $urandom_range(0, 99);
        if (r < 10) flaw = FLAW_BAD_CHECK;
        else if (r < 18) flaw = FLAW_BAD_END;
        else flaw = FLAW_NONE;
        send_frame(8'($urandom()), random_payload(len), flaw);
        sent += len + HEADER_BYTES + 2;
      end
    end
    tx_quiet = 1'b0;
  endtask

  // result side: random stall, compare each transaction with the oldest one due
  always @(posedge clk) begin
    frame_result_t want;
    int            r;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        note_failure($sformatf("unexpected result: command %0h", out_command_id));
      end else begin
        want = due_results.pop_front();
        check_field("command_id", want.command_id, out_command_id);
        check_field("frame_status", want.frame_status, out_frame_status);
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("has_payload_byte", want.has_payload_byte, out_has_payload_byte);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("last_of_frame", want.last_of_frame, out_last_of_frame);
      end
    end
    if (!rst_n || rx_quiet) begin
      out_stall <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_stall <= 1'b0;
      end else begin
        rx_hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    out_stall  <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_good_frames();
    test_bad_frames();
    test_dropped_frames();
    set_markers(8'h00, 8'hFF);
    test_random_frames(15);
    test_back_to_back();
    test_drain_pause();
    set_markers(8'hFF, 8'h00);
    test_random_frames(15);
    set_markers(8'($urandom()), 8'($urandom()));
    test_random_frames(20);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
